// ===== hw/rtl/kns_pkg.sv =====
// Kepler Newton solver: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kns_pkg;
	localparam int EccW = 30;
	localparam int TolW = 16;
	localparam int StepW = 7;
	localparam int AngW = 32;
	localparam int IdxW = 2;
	localparam int CfgW = 30;

	// register indexes
	localparam logic [IdxW-1:0] REG_ECC = 2'd0;
	localparam logic [IdxW-1:0] REG_TOL = 2'd1;
	localparam logic [IdxW-1:0] REG_STEPS = 2'd2;

	localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
	localparam logic signed [63:0] Q30_PI = 64'sd3373259426;
	localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] Q30_TWO_PI = 64'sd6746518852;
	localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
	localparam logic [63:0] STEP_CLAMP = 64'd8589934592;

	// arctangent table, Q30
	function automatic logic signed [63:0] atan_q30(input logic [5:0] i);
		logic signed [63:0] r;
		r = 64'sd0;
		case (i)
			6'd0: r = 64'sd843314857;
			6'd1: r = 64'sd497837829;
			6'd2: r = 64'sd263043837;
			6'd3: r = 64'sd133525159;
			6'd4: r = 64'sd67021687;
			6'd5: r = 64'sd33543516;
			6'd6: r = 64'sd16775851;
			6'd7: r = 64'sd8388437;
			6'd8: r = 64'sd4194283;
			6'd9: r = 64'sd2097149;
			default: begin
				if (i <= 6'd30)
					r = 64'sd1 <<< (6'd30 - i);
			end
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/kns_if.sv =====
// Valid/ready channel interface carrying one generic payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface kns_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kns_div.sv =====
// Restoring radix-2 divider, one quotient bit a cycle.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module kns_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] num,
	input wire logic [31:0] den,
	output logic done,
	output logic [63:0] quo
);
	logic [63:0] num_q;
	logic [32:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [32:0] trial;
	logic [33:0] diff;

	// shift in the next numerator bit and try a subtract
	assign trial = {rem_q[31:0], num_q[63]};
	assign diff = {1'b0, trial} - {2'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
				num_q <= num;
				rem_q <= '0;
				quo <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], 1'b0};
				if (!diff[33]) begin
					rem_q <= diff[32:0];
					quo <= {quo[62:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo <= {quo[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/kepler_newton_solver_core.sv =====
// Kepler equation solver top level: sequencer, CORDIC and Newton update.
// Depends on kns_pkg, kns_if and kns_div.
// Each Newton step reduces the angle by multiples of 2*pi (28 - FRACTION_BITS extra
// reduction rounds when positive), runs the CORDIC one iteration a cycle, then the
// serial divider; one transaction at a time, input not ready meanwhile.
// Output register holds the result until taken. Reset is asynchronous and
// loads eccentricity 0, tolerance 268 and 40 steps.
`timescale 1ns / 1ps
`default_nettype none
module kepler_newton_solver_core #(
	parameter int CORDIC_STEPS = 30,
	parameter int FRACTION_BITS = 28
) (
	input wire logic clk,
	input wire logic arst_n,
	kns_if.sink in_ch,
	kns_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [kns_pkg::IdxW-1:0] cfg_idx,
	input wire logic [kns_pkg::CfgW-1:0] cfg_data
);
	import kns_pkg::*;

	// angle format shifts and number of extra 2*pi reduction rounds
	localparam int ShL = (FRACTION_BITS <= 30) ? 30 - FRACTION_BITS : 0;
	localparam int ShR = (FRACTION_BITS > 30) ? FRACTION_BITS - 30 : 0;
	localparam int RedK = (FRACTION_BITS < 28) ? 28 - FRACTION_BITS : 0;

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_MOD, S_FOLD, S_CORD, S_MUL, S_RES, S_DIV, S_WAIT, S_UPD, S_OUT
	} state_t;

	state_t state_q;
	logic [EccW-1:0] ecc_q;
	logic [TolW-1:0] tol_q;
	logic [StepW-1:0] maxs_q, used_q;
	logic signed [63:0] m_q, e_q, z_q, x_q, y_q, f_q, d_q, es_q, ec_q;
	logic [5:0] it_q;
	logic [3:0] rk_q;
	logic neg_q, conv_q, div_start;
	logic [63:0] mag_q, quo;
	logic div_done;
	logic signed [63:0] z_in, twopi_k, dx, dy, prod, qs;
	logic signed [31:0] mul_a;
	logic [63:0] lim;

	// angle into Q30
	always_comb begin
		if (FRACTION_BITS <= 30)
			z_in = e_q <<< ShL;
		else
			z_in = e_q >>> ShR;
	end
	// 2*pi scaled for the current reduction round
	assign twopi_k = Q30_TWO_PI <<< rk_q;
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;

	// one shared 30x32 multiplier: sine then cosine
	assign mul_a = (it_q == 6'd1) ? y_q[31:0] : x_q[31:0];
	assign prod = $signed({2'b00, ecc_q}) * mul_a;

	assign lim = (mag_q > STEP_CLAMP) ? STEP_CLAMP : mag_q;
	assign qs = ($signed(quo) > $signed(STEP_CLAMP)) ? $signed(STEP_CLAMP)
		: $signed(quo);

	kns_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({lim[33:0], 30'd0}), .den(d_q[31:0]), .done(div_done), .quo(quo)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = {e_q[31:0], conv_q, used_q};
	assign div_start = (state_q == S_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ecc_q <= '0;
			tol_q <= 16'd268;
			maxs_q <= 7'd40;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_ECC: ecc_q <= cfg_data[EccW-1:0];
					REG_TOL: tol_q <= cfg_data[TolW-1:0];
					REG_STEPS: maxs_q <= cfg_data[StepW-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					m_q <= 64'(signed'(in_ch.data[31:0]));
					e_q <= 64'(signed'(in_ch.data[31:0]));
					used_q <= '0;
					conv_q <= 1'b0;
					state_q <= S_RED;
				end
				S_RED: if (used_q >= maxs_q) state_q <= S_OUT;
				else begin
					z_q <= z_in;
					rk_q <= 4'(RedK);
					state_q <= S_MOD;
				end
				// truncating remainder by 2*pi: compare and subtract, largest multiple first
				S_MOD: begin
					if (z_q >= twopi_k)
						z_q <= z_q - twopi_k;
					else if (z_q <= -twopi_k)
						z_q <= z_q + twopi_k;
					if (rk_q == 4'd0) state_q <= S_FOLD;
					else rk_q <= rk_q - 4'd1;
				end
				S_FOLD: begin
					logic signed [63:0] z;
					z = z_q;
					if (z > Q30_PI) z = z - Q30_TWO_PI;
					if (z < -Q30_PI) z = z + Q30_TWO_PI;
					neg_q <= 1'b0;
					if (z > Q30_HALF_PI) begin
						z = z - Q30_PI; neg_q <= 1'b1;
					end else if (z < -Q30_HALF_PI) begin
						z = z + Q30_PI; neg_q <= 1'b1;
					end
					z_q <= z;
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					it_q <= '0;
					state_q <= S_CORD;
				end
				// one rotation a cycle
				S_CORD: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_q30(it_q);
					end else begin
						x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_q30(it_q);
					end
					if (it_q == 6'(CORDIC_STEPS - 1)) begin
						it_q <= '0;
						state_q <= S_MUL;
					end else it_q <= it_q + 6'd1;
				end
				S_MUL: begin
					if (it_q == 6'd0) begin
						if (neg_q) y_q <= -y_q;
						if (neg_q) x_q <= -x_q;
						it_q <= 6'd1;
					end else if (it_q == 6'd1) begin
						es_q <= prod; it_q <= 6'd2;
					end else begin
						ec_q <= prod; state_q <= S_RES;
					end
				end
				S_RES: begin
					logic signed [63:0] f, d;
					f = e_q - (es_q >>> (60 - FRACTION_BITS)) - m_q;
					d = Q30_ONE - (ec_q >>> 30);
					if (d <= 0) d = 64'sd1;
					f_q <= f; d_q <= d;
					mag_q <= (f < 0) ? 64'(-f) : 64'(f);
					state_q <= S_DIV;
				end
				S_DIV: state_q <= S_WAIT;
				S_WAIT: if (div_done) state_q <= S_UPD;
				S_UPD: begin
					logic signed [63:0] en;
					en = (f_q < 0) ? e_q + qs : e_q - qs;
					if (en > 64'sd2147483647) en = 64'sd2147483647;
					if (en < -64'sd2147483648) en = -64'sd2147483648;
					e_q <= en;
					used_q <= used_q + 7'd1;
					if (mag_q < 64'(tol_q)) begin
						conv_q <= 1'b1; state_q <= S_OUT;
					end else state_q <= S_RED;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output stays within the step budget
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> used_q <= maxs_q) else $error("steps exceed limit");
	a_conv: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && conv_q |-> used_q != 7'd0) else $error("converged with no step");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
endmodule
`default_nettype wire

// ===== verif/tb_kepler_newton_solver_core.sv =====
// Testbench for kepler_newton_solver_core: directed and random mean anomalies
// checked against a Newton-Raphson/CORDIC predictor. Uses kns_pkg and kns_if.
`timescale 1ns / 1ps
module tb_kepler_newton_solver_core;
	import kns_pkg::*;

	localparam int FRAC = 28;
	localparam int CSTEPS = 30;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic signed [AngW-1:0] ecc_anomaly;
		logic converged;
		logic [StepW-1:0] steps_used;
	} solution_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IdxW-1:0] cfg_idx;
	logic [CfgW-1:0] cfg_data;

	kns_if #(.W(AngW)) anomaly_ch ();
	kns_if #(.W($bits(solution_t))) solution_ch ();

	kepler_newton_solver_core #(.CORDIC_STEPS(CSTEPS), .FRACTION_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(anomaly_ch.sink),
		.out_ch(solution_ch.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// shadow copy of the registers
	logic [EccW-1:0] ecc_reg;
	logic [TolW-1:0] tol_reg;
	logic [StepW-1:0] steps_reg;

	solution_t pending_solutions[$];
	int mismatches;
	int checked;
	int sent;
	int burst_left;
	int hold_req;
	bit no_idle;

	// clock, 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Q30 arctangent of 2^-i
	function automatic logic signed [63:0] arctan_step(input int i);
		logic signed [63:0] head[10];
		head = '{64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
			64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
			64'sd4194283, 64'sd2097149};
		if (i < 10)
			return head[i];
		if (i <= 30)
			return 64'sd1 <<< (30 - i);
		return 64'sd0;
	endfunction

	// sine and cosine of an angle, results in Q30
	task automatic sin_cos_q30(input logic signed [63:0] ang,
			output logic signed [63:0] sin_v, output logic signed [63:0] cos_v);
		logic signed [63:0] z, x, y, dx, dy;
		bit flip;
		z = (ang <<< (30 - FRAC)) % Q30_TWO_PI;
		flip = 0;
		x = CORDIC_GAIN;
		y = 64'sd0;
		if (z > Q30_PI)
			z = z - Q30_TWO_PI;
		if (z < -Q30_PI)
			z = z + Q30_TWO_PI;
		if (z > Q30_HALF_PI) begin
			z = z - Q30_PI;
			flip = 1;
		end else if (z < -Q30_HALF_PI) begin
			z = z + Q30_PI;
			flip = 1;
		end
		for (int i = 0; i < CSTEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_step(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_step(i);
			end
		end
		sin_v = flip ? -y : y;
		cos_v = flip ? -x : x;
	endtask

	// Newton-Raphson solution of E - e sin E = M with the current registers
	task automatic solve_kepler(input logic signed [AngW-1:0] mean, output solution_t sol);
		logic signed [63:0] m, e_ang, ecc, s, c, f, d, q;
		logic [63:0] mag, lim;
		int used;
		bit conv;
		m = mean;
		e_ang = m;
		ecc = {34'd0, ecc_reg};
		used = 0;
		conv = 0;
		while (used < steps_reg) begin
			sin_cos_q30(e_ang, s, c);
			f = e_ang - ((ecc * s) >>> (60 - FRAC)) - m;
			d = Q30_ONE - ((ecc * c) >>> 30);
			// derivative not positive when e is close to one
			if (d <= 0)
				d = 64'sd1;
			mag = (f < 0) ? -f : f;
			// huge residual: clamp for the division only
			lim = (mag > STEP_CLAMP) ? STEP_CLAMP : mag;
			q = (lim << 30) / d;
			if (q > $signed(STEP_CLAMP))
				q = $signed(STEP_CLAMP);
			e_ang = (f < 0) ? e_ang + q : e_ang - q;
			if (e_ang > 64'sd2147483647)
				e_ang = 64'sd2147483647;
			if (e_ang < -64'sd2147483648)
				e_ang = -64'sd2147483648;
			used++;
			if (mag < {48'd0, tol_reg}) begin
				conv = 1;
				break;
			end
		end
		sol.ecc_anomaly = e_ang[AngW-1:0];
		sol.converged = conv;
		sol.steps_used = used[StepW-1:0];
	endtask

	// register write; only called with nothing in flight
	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_ECC: ecc_reg = val[EccW-1:0];
			REG_TOL: tol_reg = val[TolW-1:0];
			REG_STEPS: steps_reg = val[StepW-1:0];
			default: ;
		endcase
	endtask

	// sender pause: wait for every outstanding transaction to come back
	task automatic drain;
		anomaly_ch.valid = 1'b0;
		while (pending_solutions.size() != 0)
			@(negedge clk);
	endtask

	// registers change only once the block is empty
	task automatic configure(input logic [EccW-1:0] e, input logic [TolW-1:0] t,
			input logic [StepW-1:0] n);
		drain();
		write_reg(REG_ECC, CfgW'(e));
		write_reg(REG_TOL, CfgW'(t));
		write_reg(REG_STEPS, CfgW'(n));
	endtask

	// offer one mean anomaly; entered and left at a falling edge
	task automatic send_anomaly(input logic signed [AngW-1:0] mean);
		solution_t sol;
		int gap;
		anomaly_ch.valid = 1'b1;
		anomaly_ch.data = mean;
		do
			@(posedge clk);
		while (!anomaly_ch.ready);
		solve_kepler(mean, sol);
		pending_solutions.push_back(sol);
		sent++;
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && !no_idle) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 6);
			anomaly_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver: random stalls in alternating stretches, plus long hold-offs
	initial begin
		int stretch;
		bit steady;
		solution_ch.ready = 1'b0;
		stretch = 0;
		steady = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				solution_ch.ready = 1'b0;
				hold_req--;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(20, 200);
					steady = ($urandom_range(0, 2) == 0);
				end
				stretch--;
				solution_ch.ready = steady ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		solution_t got, want;
		if (arst_n && solution_ch.valid && solution_ch.ready) begin
			got = solution_ch.data;
			if (pending_solutions.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("ERROR: unexpected solution E=%0d conv=%0b steps=%0d",
						got.ecc_anomaly, got.converged, got.steps_used);
			end else begin
				want = pending_solutions.pop_front();
				checked++;
				if (got.ecc_anomaly !== want.ecc_anomaly || got.converged !== want.converged
						|| got.steps_used !== want.steps_used) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("ERROR: E exp %0d got %0d, conv exp %0b got %0b, steps exp %0d got %0d",
							want.ecc_anomaly, got.ecc_anomaly, want.converged,
							got.converged, want.steps_used, got.steps_used);
				end
			end
		end
	end

	// extremes of the angle, default registers and then eccentricity 0.5
	task automatic test_angle_extremes;
		configure(EccW'(0), TolW'(268), StepW'(40));
		send_anomaly(32'sh0000_0000);
		send_anomaly(32'sh7FFF_FFFF);
		send_anomaly(32'sh8000_0000);
		configure(EccW'(30'h2000_0000), TolW'(268), StepW'(40));
		send_anomaly(32'sh3243_F6A9);
		send_anomaly(-32'sh3243_F6A9);
		send_anomaly(32'sh6487_ED51);
		send_anomaly(32'sh0000_0001);
		send_anomaly(32'shFFFF_FFFF);
		drain();
	endtask

	// eccentricity near one, where the derivative can vanish
	task automatic test_near_parabolic;
		configure(EccW'(30'h3FFF_FFFF), TolW'(268), StepW'(64));
		send_anomaly(32'sh0000_0000);
		send_anomaly(32'sh0000_0010);
		send_anomaly(32'sh7FFF_FFFF);
		send_anomaly(32'sh8000_0000);
		send_anomaly(32'sh1000_0000);
		drain();
	endtask

	// zero tolerance, zero steps, largest step count, widest tolerance
	task automatic test_step_limits;
		configure(EccW'(30'h1000_0000), TolW'(0), StepW'(5));
		send_anomaly(32'sh1234_5678);
		send_anomaly(-32'sh0765_4321);
		configure(EccW'(30'h1000_0000), TolW'(268), StepW'(0));
		send_anomaly(32'sh2000_0000);
		send_anomaly(32'sh8000_0000);
		configure(EccW'(30'h3000_0000), TolW'(0), StepW'(127));
		send_anomaly(32'sh4000_0000);
		configure(EccW'(30'h2AAA_AAAA), TolW'(16'hFFFF), StepW'(1));
		send_anomaly(32'sh5555_5555);
		send_anomaly(32'shAAAA_AAAA);
		drain();
	endtask

	// receiver holds off long while items keep coming
	task automatic test_backpressure;
		configure(EccW'(30'h0CCC_CCCC), TolW'(268), StepW'(3));
		hold_req = 2000;
		no_idle = 1;
		repeat (6) send_anomaly($urandom);
		no_idle = 0;
		drain();
	endtask

	// random phases with random registers; mostly short step limits
	task automatic test_random_phases;
		logic [EccW-1:0] e;
		logic [TolW-1:0] t;
		logic [StepW-1:0] n;
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 5))
				0: e = '0;
				1: e = '1;
				default: e = EccW'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: t = '0;
				1: t = '1;
				default: t = TolW'($urandom_range(1, 4000));
			endcase
			n = ($urandom_range(0, 5) == 0) ? StepW'($urandom_range(1, 64))
				: StepW'($urandom_range(1, 10));
			configure(e, t, n);
			no_idle = (p == 3);
			repeat (26) send_anomaly($urandom);
			no_idle = 0;
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		anomaly_ch.valid = 1'b0;
		anomaly_ch.data = '0;
		ecc_reg = '0;
		tol_reg = 16'd268;
		steps_reg = 7'd40;
		mismatches = 0;
		checked = 0;
		sent = 0;
		burst_left = 3;
		hold_req = 0;
		no_idle = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values first, before any register write
		send_anomaly(32'sh1000_0000);
		drain();
		test_angle_extremes();
		test_near_parabolic();
		test_step_limits();
		test_backpressure();
		test_random_phases();

		drain();
		repeat (50) @(negedge clk);
		if (pending_solutions.size() != 0)
			mismatches++;
		$display("Ran %0d anomalies, %0d solutions checked, %0d mismatches;", sent, checked,
			mismatches);
		$display("covered angle extremes, e near one, zero/max steps and long back-pressure.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#200ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
